// ===== hdl/arl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// arl_pkg
// Shared types and constants for the root pointer locator: word layouts,
// phase and status codes, table geometry and the default signature.
// ----------------------------------------------------------------------------
package arl_pkg;

  // table geometry
  localparam int unsigned SIG_BYTES  = 8;
  localparam int unsigned V1_LENGTH  = 20;
  localparam int unsigned V2_LENGTH  = 36;
  localparam int unsigned REV_OFFSET = 15;
  localparam int unsigned HIST_BYTES = SIG_BYTES - 1;

  localparam int unsigned ADDR_W = 20;
  localparam int unsigned OFFS_W = 6;
  localparam int unsigned CNT_W  = 3;
  localparam int unsigned SIG_W  = 8 * SIG_BYTES;
  localparam int unsigned HIST_W = 8 * HIST_BYTES;

  localparam logic [OFFS_W-1:0] OFFSET_MAX = '1;

  // revision byte codes
  localparam logic [7:0] REV_ACPI1 = 8'h00;
  localparam logic [7:0] REV_ACPI2 = 8'h02;

  // default signature "RSD PTR ", first byte in the low bits
  localparam logic [63:0] SIG_RESET = 64'h2052_5450_2044_5352;

  typedef enum logic [1:0] {
    PH_SEARCH  = 2'd0,
    PH_COLLECT = 2'd1,
    PH_DONE    = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    ST_VALID    = 3'd0,
    ST_BADSUM   = 3'd1,
    ST_BADREV   = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_TRUNC    = 3'd4
  } status_e;

  // one scanned byte with its markers
  typedef struct packed {
    logic [7:0]        data_byte;
    logic [ADDR_W-1:0] byte_addr;
    logic              scan_start;
    logic              region_first;
    logic              region_final;
    logic              scan_last;
  } item_t;

  // one report
  typedef struct packed {
    status_e           status;
    logic [ADDR_W-1:0] table_addr;
  } result_t;

  // word handed from the core to the result register
  typedef struct packed {
    logic    valid;
    result_t res;
  } report_t;

endpackage
`default_nettype wire

// ===== hdl/arl_intf.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// arl channel interfaces
// Valid/ready channels for scanned bytes, reports and the signature register.
// ----------------------------------------------------------------------------

// scanned byte channel
interface arl_item_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [19:0] byte_addr;
  logic        scan_start;
  logic        region_first;
  logic        region_final;
  logic        scan_last;

  modport source (
    output valid, data_byte, byte_addr, scan_start, region_first,
           region_final, scan_last,
    input  ready
  );
  modport sink (
    input  valid, data_byte, byte_addr, scan_start, region_first,
           region_final, scan_last,
    output ready
  );
endinterface

// report channel
interface arl_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [19:0] table_addr;

  modport source (output valid, status, table_addr, input ready);
  modport sink   (input valid, status, table_addr, output ready);
endinterface

// signature register write channel
interface arl_cfg_if;
  logic        valid;
  logic        ready;
  logic [63:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/arl_in_reg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// arl_in_reg
// Input register: holds one accepted word and hands it to the core when the
// result register can take whatever it produces.
// ----------------------------------------------------------------------------
module arl_in_reg import arl_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  input  logic  out_free_i,
  output logic  fire_o,
  output item_t item_o
);

  logic  valid_q;
  item_t item_q;

  // word moves on when the result side has room
  assign fire_o     = valid_q & out_free_i;
  assign in_ready_o = ~valid_q | out_free_i;
  assign item_o     = item_q;

  // occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/arl_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// arl_core
// Signature match against the byte history, table gathering with the two
// checksums and revision capture, and the verdict for each scan.
// ----------------------------------------------------------------------------
module arl_core import arl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  item_t            item_i,
  input  logic [SIG_W-1:0] sig_i,
  output report_t          report_o
);

  phase_e            phase_q, phase_d;
  logic [HIST_W-1:0] hist_q, hist_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [ADDR_W-1:0] maddr_q, maddr_d;
  logic [OFFS_W-1:0] offs_q, offs_d;
  logic [7:0]        sum1_q, sum1_d;
  logic [7:0]        sum2_q, sum2_d;
  logic [7:0]        rev_q, rev_d;

  // working copies after the restart and region markers
  phase_e            ph;
  logic [HIST_W-1:0] hist;
  logic [CNT_W-1:0]  cnt;
  logic [ADDR_W-1:0] maddr;
  logic [OFFS_W-1:0] offs;
  logic [7:0]        sum1, sum2, rev;
  logic [SIG_W-1:0]  window;
  logic              sig_eq, hit;
  logic [7:0]        sig_sum;
  logic              judged;
  status_e           verdict;

  always_comb begin
    ph    = item_i.scan_start ? PH_SEARCH : phase_q;
    maddr = item_i.scan_start ? '0 : maddr_q;
    offs  = item_i.scan_start ? '0 : offs_q;
    sum1  = item_i.scan_start ? '0 : sum1_q;
    sum2  = item_i.scan_start ? '0 : sum2_q;
    rev   = item_i.scan_start ? '0 : rev_q;
    hist  = (item_i.scan_start | item_i.region_first) ? '0 : hist_q;
    cnt   = (item_i.scan_start | item_i.region_first) ? '0 : cnt_q;
  end

  // compare window, newest byte lowest, against the reversed signature
  assign window = {hist, item_i.data_byte};

  always_comb begin
    sig_eq = 1'b1;
    for (int j = 0; j < SIG_BYTES; j++) begin
      if (window[8*j +: 8] != sig_i[8*(SIG_BYTES-1-j) +: 8]) begin
        sig_eq = 1'b0;
      end
    end
  end

  assign hit = (ph == PH_SEARCH) && !item_i.region_final &&
               (cnt == CNT_W'(HIST_BYTES)) && sig_eq;

  // checksum contribution of the signature bytes themselves
  always_comb begin
    sig_sum = '0;
    for (int j = 0; j < SIG_BYTES; j++) begin
      sig_sum = sig_sum + sig_i[8*j +: 8];
    end
  end

  // next state and verdict
  always_comb begin
    phase_d = ph;
    maddr_d = maddr;
    offs_d  = offs;
    sum1_d  = sum1;
    sum2_d  = sum2;
    rev_d   = rev;
    judged  = 1'b0;
    verdict = ST_VALID;
    report_o.valid          = 1'b0;
    report_o.res.status     = ST_VALID;
    report_o.res.table_addr = '0;

    // history shifts on every word
    hist_d = {hist[HIST_W-9:0], item_i.data_byte};
    cnt_d  = (cnt == CNT_W'(HIST_BYTES)) ? cnt : cnt + 1'b1;

    case (ph)
      PH_SEARCH: begin
        if (hit) begin
          // signature bytes open the table; the revision byte is past them
          phase_d = PH_COLLECT;
          maddr_d = item_i.byte_addr - ADDR_W'(SIG_BYTES - 1);
          offs_d  = OFFS_W'(SIG_BYTES);
          sum1_d  = sum1 + sig_sum;
          if (item_i.scan_last) begin
            phase_d = PH_DONE;
            report_o.valid          = 1'b1;
            report_o.res.status     = ST_TRUNC;
            report_o.res.table_addr = maddr_d;
          end
        end else if (item_i.scan_last) begin
          phase_d = PH_DONE;
          report_o.valid          = 1'b1;
          report_o.res.status     = ST_NOTFOUND;
          report_o.res.table_addr = '0;
        end
      end
      PH_COLLECT: begin
        // gather one table byte
        if (offs < OFFS_W'(V1_LENGTH)) begin
          sum1_d = sum1 + item_i.data_byte;
        end else if (offs < OFFS_W'(V2_LENGTH)) begin
          sum2_d = sum2 + item_i.data_byte;
        end
        if (offs == OFFS_W'(REV_OFFSET)) begin
          rev_d = item_i.data_byte;
        end
        if (offs != OFFSET_MAX) begin
          offs_d = offs + 1'b1;
        end

        // judge on the updated counts
        if (offs_d >= OFFS_W'(REV_OFFSET + 1)) begin
          if (rev_d == REV_ACPI1) begin
            if (offs_d >= OFFS_W'(V1_LENGTH)) begin
              judged  = 1'b1;
              verdict = (sum1_d == '0) ? ST_VALID : ST_BADSUM;
            end
          end else if (rev_d == REV_ACPI2) begin
            if (offs_d >= OFFS_W'(V2_LENGTH)) begin
              judged  = 1'b1;
              verdict = (sum1_d == '0 && sum2_d == '0) ? ST_VALID : ST_BADSUM;
            end
          end else begin
            judged  = 1'b1;
            verdict = ST_BADREV;
          end
        end

        if (!judged && (item_i.region_final || item_i.scan_last)) begin
          judged  = 1'b1;
          verdict = ST_TRUNC;
        end
        if (judged) begin
          phase_d = PH_DONE;
          report_o.valid          = 1'b1;
          report_o.res.status     = verdict;
          report_o.res.table_addr = maddr;
        end
      end
      default: begin
        // done: wait for the next scan
        phase_d = ph;
      end
    endcase

    report_o.valid = report_o.valid & fire_i;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEARCH;
      hist_q  <= '0;
      cnt_q   <= '0;
      maddr_q <= '0;
      offs_q  <= '0;
      sum1_q  <= '0;
      sum2_q  <= '0;
      rev_q   <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      hist_q  <= hist_d;
      cnt_q   <= cnt_d;
      maddr_q <= maddr_d;
      offs_q  <= offs_d;
      sum1_q  <= sum1_d;
      sum2_q  <= sum2_d;
      rev_q   <= rev_d;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/arl_out_reg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// arl_out_reg
// Result register: holds one report until the sink takes it.
// ----------------------------------------------------------------------------
module arl_out_reg import arl_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  report_t report_i,
  output logic    free_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t res_o
);

  logic    valid_q;
  result_t res_q;

  // room when empty or being emptied this cycle
  assign free_o  = ~valid_q | ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= report_i.valid;
    end
  end

  // report payload
  always_ff @(posedge clk_i) begin
    if (free_o && report_i.valid) begin
      res_q <= report_i.res;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/acpi_rsdp_locator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// acpi_rsdp_locator
// Finds the root system description pointer in a byte scan and checks it.
// ----------------------------------------------------------------------------
// Takes one scanned byte per cycle, with no gaps of its own, while the result
// register has room. Each word is registered at the input, passes once
// through the match, checksum and verdict logic, and the report lands in a
// result register. While a report sits in that register and the sink does
// not take it, the input register cannot hand on its word, so the input
// stalls until the report is taken.
// At most one report per scan: status and table start address, or not found
// with address zero.
// The signature register is written through the configuration channel,
// which is always ready, and resets to "RSD PTR ".
module acpi_rsdp_locator import arl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  arl_item_if.sink     in_i,
  arl_result_if.source res_o,
  arl_cfg_if.sink      cfg_i
);

  logic             [SIG_W-1:0] sig_q;
  item_t            in_item;
  item_t            cur_item;
  logic             fire;
  logic             out_free;
  report_t          report;
  result_t          res;

  // signature register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sig_q <= SIG_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      sig_q <= cfg_i.data;
    end
  end

  // pack incoming word
  assign in_item.data_byte    = in_i.data_byte;
  assign in_item.byte_addr    = in_i.byte_addr;
  assign in_item.scan_start   = in_i.scan_start;
  assign in_item.region_first = in_i.region_first;
  assign in_item.region_final = in_i.region_final;
  assign in_item.scan_last    = in_i.scan_last;

  arl_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .in_item_i  (in_item),
    .out_free_i (out_free),
    .fire_o     (fire),
    .item_o     (cur_item)
  );

  arl_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (cur_item),
    .sig_i    (sig_q),
    .report_o (report)
  );

  arl_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .report_i (report),
    .free_o   (out_free),
    .valid_o  (res_o.valid),
    .ready_i  (res_o.ready),
    .res_o    (res)
  );

  // unpack report
  assign res_o.status     = res.status;
  assign res_o.table_addr = res.table_addr;

endmodule
`default_nettype wire
